@@ rtl/bpl_pkg.sv @@
// Package: payload types and fixed-point constants for the Blinn-Phong light term core.
`default_nettype none
package bpl_pkg;

  localparam int unsigned CompW = 16;
  localparam int unsigned OutW  = 17;
  localparam logic [14:0] OneQ14 = 15'd16384;
  localparam logic [16:0] OutMax = 17'd131071;

  typedef struct packed {
    logic [15:0] shine_exponent;
    logic [47:0] specular_rgb;
    logic [47:0] diffuse_rgb;
    logic [47:0] light_rgb;
    logic [47:0] half_vector;
    logic [47:0] light_direction;
    logic [47:0] surface_normal;
  } bpl_in_t;

  typedef struct packed {
    logic [16:0] out_blue;
    logic [16:0] out_green;
    logic [16:0] out_red;
  } bpl_out_t;

  // Clamp a Q2.28 dot-product sum to Q1.14 in [0, 1.0].
  function automatic logic [14:0] clamp_dot(input logic signed [34:0] sum);
    logic [20:0] t;
    begin
      t = sum[34:14];
      if (sum <= 35'sd0) clamp_dot = 15'd0;
      else if (t > 21'd16384) clamp_dot = OneQ14;
      else clamp_dot = t[14:0];
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/blinn_phong_light_term_core.sv @@
// Top level: pipelined Blinn-Phong per-light diffuse plus specular term.
// One transaction per cycle unless the output stalls. The 8 register stages
// are: dot products, clamp, log2 lookup, exponent multiply, exp2 lookup and
// shift, color products, scale by dot term and power, and channel sum and
// saturate into the output register. in_ready is high when the last stage
// is empty or out_ready is high; a stall freezes every stage so nothing is
// lost or repeated. Results are unsigned Q3.14, saturating.
// POW_TABLE_ADDR_BITS sets the depth of the log2 and exp2 tables (6..12).
`default_nettype none
module blinn_phong_light_term_core #(
  parameter int unsigned POW_TABLE_ADDR_BITS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire bpl_pkg::bpl_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output bpl_pkg::bpl_out_t     out_data
);
  import bpl_pkg::*;
  localparam int unsigned A = POW_TABLE_ADDR_BITS;
  localparam int unsigned NS = 8;

  logic [NS-1:0] vld;
  logic          adv;
  // Advance whole pipeline unless the output holds an untaken result.
  assign adv      = !vld[NS-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  // Stage 1: six signed products.
  logic signed [31:0] p_l [3];
  logic signed [31:0] p_h [3];
  logic [47:0] s1_l, s1_d, s1_s;
  logic [15:0] s1_e;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        p_l[c] <= $signed(in_data.surface_normal[16*c +: 16]) *
                  $signed(in_data.light_direction[16*c +: 16]);
        p_h[c] <= $signed(in_data.surface_normal[16*c +: 16]) *
                  $signed(in_data.half_vector[16*c +: 16]);
      end
      s1_l <= in_data.light_rgb; s1_d <= in_data.diffuse_rgb;
      s1_s <= in_data.specular_rgb; s1_e <= in_data.shine_exponent;
    end
  end

  // Stage 2: sum and clamp N.L and N.H.
  logic [14:0] s2_ndl, s2_ndh;
  logic [47:0] s2_l, s2_d, s2_s;
  logic [15:0] s2_e;
  logic [14:0] ndh_c;
  always_comb begin
    ndh_c = clamp_dot(35'(p_h[0]) + 35'(p_h[1]) + 35'(p_h[2]));
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ndl <= clamp_dot(35'(p_l[0]) + 35'(p_l[1]) + 35'(p_l[2]));
      s2_ndh <= ndh_c;
      s2_l <= s1_l; s2_d <= s1_d; s2_s <= s1_s; s2_e <= s1_e;
    end
  end

  // Stage 3: normalize base, log2 lookup, form -log2(x) in Q.16.
  // lz is 13 minus the leading-one position; -log2(x) is lz + 1 minus the log2
  // of the mantissa, whose fraction bits sit below the leading one.
  logic [3:0]  lz;
  logic [13:0] mant;
  logic [15:0] log_q;
  logic [31:0] exp_q;
  logic [A-1:0] exp_addr;
  always_comb begin
    lz = 4'd0;
    for (int b = 0; b < 14; b++) begin
      if (s2_ndh[b]) lz = 4'(13 - b);
    end
    mant = 14'(s2_ndh[13:0] << (lz + 4'd1));
  end
  bpl_pow_rom #(.AddrBits(A)) u_rom (
    .log_addr(mant[13 -: A]), .log_data(log_q),
    .exp_addr(exp_addr), .exp_data(exp_q)
  );
  logic [19:0] s3_lg;
  logic [1:0]  s3_sp; // special: 0 none, 1 -> one, 2 -> zero
  logic [14:0] s3_ndl;
  logic [47:0] s3_l, s3_d, s3_s;
  logic [15:0] s3_e;
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_lg <= {lz + 4'd1, 16'd0} - 20'(log_q);
      if (s2_ndh == 15'd0) s3_sp <= (s2_e == 16'd0) ? 2'd1 : 2'd2;
      else if (s2_e == 16'd0 || s2_ndh[14]) s3_sp <= 2'd1;
      else s3_sp <= 2'd0;
      s3_ndl <= s2_ndl;
      s3_l <= s2_l; s3_d <= s2_d; s3_s <= s2_s; s3_e <= s2_e;
    end
  end

  // Stage 4: multiply log by exponent.
  logic [27:0] s4_y;
  logic [1:0]  s4_sp;
  logic [14:0] s4_ndl;
  logic [47:0] s4_l, s4_d, s4_s;
  logic [35:0] ym;
  assign ym = 36'(s3_lg) * 36'(s3_e);
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_y <= ym[35:8];
      s4_sp <= s3_sp; s4_ndl <= s3_ndl;
      s4_l <= s3_l; s4_d <= s3_d; s4_s <= s3_s;
    end
  end

  // Stage 5: exp2 lookup and shift.
  logic [14:0] pw;
  logic [11:0] yi;
  logic [63:0] esh;
  assign exp_addr = s4_y[15 -: A];
  assign yi = s4_y[27:16];
  assign esh = 64'(exp_q) >> (yi[3:0] + 5'd16);
  always_comb begin
    case (s4_sp)
      2'd1:    pw = OneQ14;
      2'd2:    pw = 15'd0;
      default: pw = (yi >= 12'd15) ? 15'd0 : esh[14:0];
    endcase
  end
  logic [14:0] s5_pw, s5_ndl;
  logic [47:0] s5_l, s5_d, s5_s;
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_pw <= pw; s5_ndl <= s4_ndl;
      s5_l <= s4_l; s5_d <= s4_d; s5_s <= s4_s;
    end
  end

  // Stage 6: material times light.
  logic [31:0] s6_dl [3];
  logic [31:0] s6_sl [3];
  logic [14:0] s6_pw, s6_ndl;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        s6_dl[c] <= 32'(s5_d[16*c +: 16]) * 32'(s5_l[16*c +: 16]);
        s6_sl[c] <= 32'(s5_s[16*c +: 16]) * 32'(s5_l[16*c +: 16]);
      end
      s6_pw <= s5_pw; s6_ndl <= s5_ndl;
    end
  end

  // Stage 7: scale by dot term and power.
  logic [46:0] s7_a [3];
  logic [46:0] s7_b [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        s7_a[c] <= 47'(s6_dl[c]) * 47'(s6_ndl);
        s7_b[c] <= 47'(s6_sl[c]) * 47'(s6_pw);
      end
    end
  end

  // Stage 8: sum, truncate, saturate.
  logic [47:0] tot [3];
  logic [16:0] ch  [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tot[c] = 48'(s7_a[c]) + 48'(s7_b[c]);
      ch[c]  = (tot[c][47:30] > 18'(OutMax)) ? OutMax : tot[c][46:30];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.out_red   <= ch[0];
      out_data.out_green <= ch[1];
      out_data.out_blue  <= ch[2];
    end
  end
endmodule
`default_nettype wire

@@ rtl/bpl_pow_rom.sv @@
// Log2 and exp2 lookup tables for the specular power, computed at elaboration.
`default_nettype none
module bpl_pow_rom #(
  parameter int unsigned AddrBits = 8
) (
  input  wire logic [AddrBits-1:0] log_addr,
  output logic      [15:0]         log_data,
  input  wire logic [AddrBits-1:0] exp_addr,
  output logic      [31:0]         exp_data
);
  localparam int unsigned Depth = 1 << AddrBits;

  function automatic logic [63:0] isqrt(input logic [63:0] v_in);
    logic [63:0] v, res, b;
    begin
      v = v_in; res = 64'd0; b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 64'd0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      isqrt = res;
    end
  endfunction

  function automatic logic [15:0] log_entry(input int unsigned i);
    logic [63:0] m;
    logic [15:0] r;
    begin
      m = 64'(Depth + i) << (30 - AddrBits);
      r = 16'd0;
      for (int k = 0; k < 16; k++) begin
        m = (m * m) >> 30;
        r = r << 1;
        if (m >= (64'd1 << 31)) begin
          m = m >> 1;
          r[0] = 1'b1;
        end
      end
      log_entry = r;
    end
  endfunction

  function automatic logic [31:0] exp_entry(input int unsigned j);
    logic [63:0] v, r;
    begin
      v = 64'd1 << 30;
      r = isqrt(64'd1 << 59);
      for (int k = 1; k <= AddrBits; k++) begin
        if (((j >> (AddrBits - k)) & 1) != 0) v = (v * r) >> 30;
        r = isqrt(r << 30);
      end
      exp_entry = v[31:0];
    end
  endfunction

  logic [15:0] log_tab [Depth];
  logic [31:0] exp_tab [Depth];

  for (genvar g = 0; g < Depth; g++) begin : g_tab
    assign log_tab[g] = log_entry(g);
    assign exp_tab[g] = exp_entry(g);
  end

  assign log_data = log_tab[log_addr];
  assign exp_data = exp_tab[exp_addr];
endmodule
`default_nettype wire
